// ----- src/mpdc_pkg.sv -----
// Shared constants and types for the modular power product block.
// No dependencies; every other file of the block depends on this package.
package mpdc_pkg;

   localparam int COUNT_WIDTH = 63;
   localparam int BASE_WIDTH  = 30;

   localparam logic [BASE_WIDTH-1:0] PRIME_MOD = 30'd1000000007;
   localparam logic [31:0] TWO_PRIME = 32'd2000000014;

   // Barrett reciprocal: floor(2^61 / PRIME_MOD), fits in 32 bits
   localparam logic [31:0] BARRETT_M = 32'((64'd1 << 61) / 64'(PRIME_MOD));

   // register indexes on the configuration port
   localparam logic REG_EVEN_BASE = 1'b0;
   localparam logic REG_ODD_BASE  = 1'b1;

   typedef struct packed {
      logic                  start;
      logic [BASE_WIDTH-1:0] op_a;
      logic [BASE_WIDTH-1:0] op_b;
   } mm_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [BASE_WIDTH-1:0] result;
   } mm_rsp_type;

endpackage

// ----- src/mpdc_req_if.sv -----
// Request channel: valid/ready handshake carrying the digit count.
// Depends on mpdc_pkg for the field width.
interface mpdc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [mpdc_pkg::COUNT_WIDTH-1:0]     digit_count;

   modport source (output valid, output digit_count, input ready);
   modport sink   (input valid, input digit_count, output ready);
endinterface

// ----- src/mpdc_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the modular count.
// Depends on mpdc_pkg for the field width.
interface mpdc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mpdc_pkg::BASE_WIDTH-1:0]      count_mod;

   modport source (output valid, output count_mod, input ready);
   modport sink   (input valid, input count_mod, output ready);
endinterface

// ----- src/mpdc_modmul.sv -----
// Iterative modular multiplier: (a * b) mod PRIME_MOD by Barrett reduction.
// One 32x32 multiplier is reused for the product and both Barrett steps.
// Depends on mpdc_pkg.
module mpdc_modmul (
   input  logic                clock,
   input  logic                reset,
   input  mpdc_pkg::mm_cmd_type cmd,
   output mpdc_pkg::mm_rsp_type rsp
);
   import mpdc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EST,
      S_QP,
      S_FIX
   } state_type;

   state_type             state_ff, state_in;
   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           x_lo_ff, x_lo_in;
   logic                  done_ff, done_in;
   logic [BASE_WIDTH-1:0] result_ff, result_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [31:0] rem;

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            mul_a = {2'b00, cmd.op_a};
            mul_b = {2'b00, cmd.op_b};
         end
         S_EST: begin
            mul_a = {1'b0, prod_ff[59:29]};
            mul_b = BARRETT_M;
         end
         S_QP: begin
            mul_a = prod_ff[63:32];
            mul_b = {2'b00, PRIME_MOD};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   // estimate is at most two short, so the remainder stays below 3P
   assign rem   = x_lo_ff - prod_ff[31:0];

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      x_lo_in   = x_lo_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               prod_in  = mul_p;
               state_in = S_EST;
            end
         end
         S_EST: begin
            x_lo_in  = prod_ff[31:0];
            prod_in  = mul_p;
            state_in = S_QP;
         end
         S_QP: begin
            prod_in  = mul_p;
            state_in = S_FIX;
         end
         S_FIX: begin
            if (rem >= TWO_PRIME) begin
               result_in = BASE_WIDTH'(rem - TWO_PRIME);
            end else if (rem >= {2'b00, PRIME_MOD}) begin
               result_in = BASE_WIDTH'(rem - {2'b00, PRIME_MOD});
            end else begin
               result_in = rem[BASE_WIDTH-1:0];
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      x_lo_ff   <= x_lo_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

// ----- src/mod_pow_digit_choice_count.sv -----
// Modular power product: even_base^ceil(n/2) * odd_base^floor(n/2) mod 1e9+7.
// Computed as (even_base*odd_base)^floor(n/2), times even_base when n is odd.
// With L = bit length and K = set bits of floor(n/2), there are L + K multiplies in all,
// base product included, or the base product alone when floor(n/2) is zero.
// Each multiply runs on the shared modmul unit.
// One request at a time; a new request is accepted only in the idle state.
// Synchronous reset sets bases 5, 4.
module mod_pow_digit_choice_count (
   input  logic        clock,
   input  logic        reset,
   mpdc_req_if.sink    req_ch,
   mpdc_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mpdc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_WAIT_PREP,
      S_STEP,
      S_WAIT_ACC,
      S_WAIT_SQR,
      S_DELIVER
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] expo_ff, expo_in;
   logic [BASE_WIDTH-1:0]  acc_ff, acc_in;
   logic [BASE_WIDTH-1:0]  base_ff, base_in;
   logic [BASE_WIDTH-1:0]  even_base_ff, even_base_in;
   logic [BASE_WIDTH-1:0]  odd_base_ff, odd_base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BASE_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                   csr_wr;
   logic [BASE_WIDTH-1:0]  even_red;
   mm_cmd_type             mm_cmd;
   mm_rsp_type             mm_rsp;

   mpdc_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cmd   (mm_cmd),
      .rsp   (mm_rsp)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_ODD_BASE) ? {2'b00, odd_base_ff}
                                                      : {2'b00, even_base_ff};

   assign even_red = (even_base_ff >= PRIME_MOD) ? even_base_ff - PRIME_MOD
                                                 : even_base_ff;

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.count_mod = rsp_count_ff;

   // issue a multiply on the cycle the sequencer leaves PREP, or STEP with a nonzero exponent
   always_comb begin
      mm_cmd.start = 1'b0;
      mm_cmd.op_a  = base_ff;
      mm_cmd.op_b  = base_ff;
      if (state_ff == S_PREP) begin
         mm_cmd.start = 1'b1;
         mm_cmd.op_a  = even_base_ff;
         mm_cmd.op_b  = odd_base_ff;
      end else if (state_ff == S_STEP && expo_ff != '0) begin
         mm_cmd.start = 1'b1;
         if (expo_ff[0]) begin
            mm_cmd.op_a = acc_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      expo_in      = expo_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      even_base_in = even_base_ff;
      odd_base_in  = odd_base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in = rsp_count_ff;

      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_EVEN_BASE: even_base_in = csr_pwdata[BASE_WIDTH-1:0];
            REG_ODD_BASE:  odd_base_in  = csr_pwdata[BASE_WIDTH-1:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               expo_in  = req_ch.digit_count >> 1;
               acc_in   = req_ch.digit_count[0] ? even_red : BASE_WIDTH'(1);
               state_in = S_PREP;
            end
         end
         S_PREP: state_in = S_WAIT_PREP;
         S_WAIT_PREP: begin
            if (mm_rsp.done) begin
               base_in  = mm_rsp.result;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (expo_ff == '0) begin
               state_in = S_DELIVER;
            end else if (expo_ff[0]) begin
               state_in = S_WAIT_ACC;
            end else begin
               state_in = S_WAIT_SQR;
            end
         end
         S_WAIT_ACC: begin
            if (mm_rsp.done) begin
               acc_in   = mm_rsp.result;
               expo_in  = expo_ff & ~COUNT_WIDTH'(1);
               state_in = S_STEP;
            end
         end
         S_WAIT_SQR: begin
            if (mm_rsp.done) begin
               base_in  = mm_rsp.result;
               expo_in  = expo_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         even_base_ff <= BASE_WIDTH'(5);
         odd_base_ff  <= BASE_WIDTH'(4);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         even_base_ff <= even_base_in;
         odd_base_ff  <= odd_base_in;
      end
      expo_ff      <= expo_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

// ----- tb/mpdc_count_checker.sv -----
// Checker for the modular power product block: tracks the base registers from
// the configuration port, predicts each count and compares it with the response.
// Depends on mpdc_pkg and the mpdc_req_if / mpdc_rsp_if channel interfaces.
module mpdc_count_checker (
   input  logic        clock,
   input  logic        reset,
   mpdc_req_if         req_ch,
   mpdc_rsp_if         rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        run_done,
   output int          pending_count,
   output int          fail_count
);
   import mpdc_pkg::*;

   localparam logic [63:0]           MODULUS    = 64'd1000000007;
   localparam logic [BASE_WIDTH-1:0] EVEN_RESET = 30'd5;
   localparam logic [BASE_WIDTH-1:0] ODD_RESET  = 30'd4;

   logic [BASE_WIDTH-1:0] even_base = EVEN_RESET;
   logic [BASE_WIDTH-1:0] odd_base  = ODD_RESET;
   logic [BASE_WIDTH-1:0] expected_counts[$];
   logic [BASE_WIDTH-1:0] want;
   bit                    leftovers_checked = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % MODULUS;
   endfunction

   // square-and-multiply over the exponent bits, base reduced first
   function automatic logic [63:0] raise_mod(input logic [63:0] base, input logic [63:0] expo);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1;
      sq  = base % MODULUS;
      for (int k = 0; k < 64; k++) begin
         if (expo[k])
            acc = mod_product(acc, sq);
         sq = mod_product(sq, sq);
      end
      return acc;
   endfunction

   function automatic logic [BASE_WIDTH-1:0] predict_count(input logic [COUNT_WIDTH-1:0] n);
      logic [63:0] even_exp;
      logic [63:0] odd_exp;
      even_exp = ({1'b0, n} + 64'd1) >> 1;
      odd_exp  = {1'b0, n} >> 1;
      return BASE_WIDTH'(mod_product(raise_mod(64'(even_base), even_exp),
                                     raise_mod(64'(odd_base), odd_exp)));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         even_base = EVEN_RESET;
         odd_base  = ODD_RESET;
         expected_counts.delete();
         pending_count <= 0;
      end else begin
         // retire a response before taking a new request on the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("count %0d with no request outstanding",
                                         rsp_ch.count_mod));
            end else begin
               want = expected_counts.pop_front();
               if (rsp_ch.count_mod !== want)
                  report_mismatch($sformatf("count_mod %0d, expected %0d",
                                            rsp_ch.count_mod, want));
            end
         end
         // predict with the bases in force before any write on this edge
         if (req_ch.valid && req_ch.ready)
            expected_counts.push_back(predict_count(req_ch.digit_count));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_EVEN_BASE)
               even_base = csr_pwdata[BASE_WIDTH-1:0];
            else if (csr_paddr[2] == REG_ODD_BASE)
               odd_base = csr_pwdata[BASE_WIDTH-1:0];
         end
         pending_count <= expected_counts.size();
         if (run_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_counts.size() != 0)
               report_mismatch($sformatf("%0d counts never returned", expected_counts.size()));
         end
      end
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the modular power product testbench: clock, reset, request and CSR
// stimulus, response back-pressure and the verdict.
// Depends on mpdc_pkg, the channel interfaces, the block and mpdc_count_checker.
module testbench;
   import mpdc_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 700;
   localparam int LONG_HOLD    = 1500;
   localparam int BATCH_ITEMS  = 45;

   localparam logic [31:0] BASE_TOP   = 32'd1000000006;
   localparam logic [31:0] BASE_PRIME = 32'd1000000007;
   localparam logic [31:0] BASE_ONES  = 32'h3FFF_FFFF;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        run_done = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_taken = 1'b0;
   int          pending_count;
   int          fail_count;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_left = 0;
   int          cycle_count = 0;

   mpdc_req_if req_ch();
   mpdc_rsp_if rsp_ch();

   mod_pow_digit_choice_count i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mpdc_count_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .run_done      (run_done),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response back-pressure; a long hold counts down here
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_base(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_bases(input logic [31:0] even_val, input logic [31:0] odd_val);
      wait_drained();
      write_base(REG_EVEN_BASE, even_val);
      write_base(REG_ODD_BASE, odd_val);
   endtask

   // hold valid across back-to-back requests; drop it only for an idle gap
   task automatic send_count(input logic [COUNT_WIDTH-1:0] n);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.digit_count <= n;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [31:0] pick_base();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return BASE_TOP;
         3:       return BASE_PRIME;
         4:       return BASE_ONES;
         5:       return $urandom;
         default: return $urandom_range(BASE_TOP);
      endcase
   endfunction

   // mix full-width counts with short ones to keep the run time down
   function automatic logic [COUNT_WIDTH-1:0] pick_count();
      logic [63:0] raw;
      int          width;
      raw = {$urandom, $urandom};
      case ($urandom_range(3))
         0:       return raw[COUNT_WIDTH-1:0];
         1:       return COUNT_WIDTH'($urandom_range(40));
         default: begin
            width = $urandom_range(COUNT_WIDTH, 1);
            return raw[COUNT_WIDTH-1:0] >> (COUNT_WIDTH - width);
         end
      endcase
   endfunction

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.digit_count = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset bases, small and extreme lengths
      for (int n = 0; n < 8; n++)
         send_count(COUNT_WIDTH'(n));
      send_count(COUNT_MAX);
      send_count(COUNT_MAX - 1'b1);
      send_count({1'b1, {(COUNT_WIDTH-1){1'b0}}});
      send_count(COUNT_WIDTH'({((COUNT_WIDTH+1)/2){2'b01}}));
      send_count(COUNT_WIDTH'({((COUNT_WIDTH+1)/2){2'b10}}));
      send_count(COUNT_WIDTH'(BASE_TOP));
      send_count(COUNT_WIDTH'(BASE_TOP - 1));
      req_ch.valid <= 1'b0;

      // zero bases: a zero exponent still gives one
      set_bases(32'd0, 32'd0);
      for (int n = 0; n < 3; n++)
         send_count(COUNT_WIDTH'(n));
      req_ch.valid <= 1'b0;

      // bases at or above the prime
      set_bases(BASE_ONES, BASE_PRIME);
      for (int n = 1; n < 4; n++)
         send_count(COUNT_WIDTH'(n));
      req_ch.valid <= 1'b0;

      // top bits of the write data are dropped
      set_bases(32'hC000_0000 | BASE_TOP, 32'hC000_0000 | BASE_TOP);
      send_count(COUNT_MAX);
      send_count(COUNT_WIDTH'(3));
      req_ch.valid <= 1'b0;

      for (int scheme = 0; scheme < 3; scheme++) begin
         send_idle_pct = (scheme == 0) ? 15 : (scheme == 1) ? 81 : 0;
         recv_idle_pct = (scheme == 0) ? 81 : (scheme == 1) ? 15 : 0;
         for (int setting = 0; setting < 3; setting++) begin
            set_bases(pick_base(), pick_base());
            // starve the response side while requests keep coming
            if (scheme == 2 && setting == 1)
               hold_go <= 1'b1;
            repeat (BATCH_ITEMS) send_count(pick_count());
            req_ch.valid <= 1'b0;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
